// ----- src/lru_kt_pkg.sv -----
// ---------------------------------------------------------------------------
// lru_kt_pkg
// Shared widths, codes and controller/datapath interface types for the
// LRU key tracker.
// ---------------------------------------------------------------------------
package lru_kt_pkg;

   localparam int KEY_W = 32;
   localparam int CAP_W = 5;
   localparam int OCC_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_HIT,
      OP_EVICT,
      OP_INSERT
   } op_type;

   typedef struct packed {
      logic   capture;
      logic   lookup;
      logic   finish;
      op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hit;
      logic full;
      logic victim_found;
      logic free_found;
   } ctrl_sts_type;

endpackage

// ----- src/lru_kt_ctrl.sv -----
// ---------------------------------------------------------------------------
// lru_kt_ctrl
// Sequencer for the LRU key tracker: capture, lookup, update, and the
// one-cycle result strobe.
// ---------------------------------------------------------------------------
module lru_kt_ctrl import lru_kt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd,
   output logic         rsp_valid
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '{capture: 1'b0, lookup: 1'b0, finish: 1'b0, op: OP_NONE};
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.finish = 1'b1;
            if (sts.hit) begin
               cmd.op = OP_HIT;
            end else if (sts.full) begin
               cmd.op = sts.victim_found ? OP_EVICT : OP_NONE;
            end else begin
               cmd.op = sts.free_found ? OP_INSERT : OP_NONE;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/lru_kt_dpath.sv -----
// ---------------------------------------------------------------------------
// lru_kt_dpath
// Key store, recency ranks, occupancy and capacity register, with the
// parallel match and the registered result.
// ---------------------------------------------------------------------------
module lru_kt_dpath import lru_kt_pkg::*; #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [KEY_W-1:0] req_key,
   input  logic             csr_valid,
   input  logic [CAP_W-1:0] csr_wdata,
   input  ctrl_cmd_type     cmd,
   output ctrl_sts_type     sts,
   output logic             rsp_hit,
   output logic             rsp_evicted_valid,
   output logic [KEY_W-1:0] rsp_evicted_key,
   output logic [OCC_W-1:0] rsp_occupancy
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [KEY_W-1:0]  key_ff;
   logic [CAP_W-1:0]  cap_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              valid_ff [MAX_ENTRIES];
   logic              valid_in [MAX_ENTRIES];
   logic [KEY_W-1:0]  keys_ff  [MAX_ENTRIES];
   logic [KEY_W-1:0]  keys_in  [MAX_ENTRIES];
   logic [RANK_W-1:0] rank_ff  [MAX_ENTRIES];
   logic [RANK_W-1:0] rank_in  [MAX_ENTRIES];

   logic              hit_ff, full_ff, victim_found_ff, free_found_ff;
   logic [IDX_W-1:0]  hit_idx_ff, victim_idx_ff, free_idx_ff;
   logic [RANK_W-1:0] hit_rank_ff;

   logic              rsp_hit_ff, rsp_hit_in;
   logic              rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [KEY_W-1:0]  rsp_ev_key_ff, rsp_ev_key_in;
   logic [OCC_W-1:0]  rsp_occ_ff, rsp_occ_in;

   logic              hit_c, victim_found_c, free_found_c, full_c;
   logic [IDX_W-1:0]  hit_idx_c, victim_idx_c, free_idx_c;
   logic [RANK_W-1:0] last_rank;
   logic [CMP_W-1:0]  cap_ext, eff_cap, count_ext, occ_ext;

   logic [IDX_W-1:0]  tgt;
   logic [RANK_W-1:0] limit;
   logic              use_limit;

   // Ranks stay dense over the valid entries, so the oldest holds count-1.
   assign last_rank = RANK_W'(count_ff - CNT_W'(1));

   always_comb begin
      hit_c          = 1'b0;
      victim_found_c = 1'b0;
      free_found_c   = 1'b0;
      hit_idx_c      = '0;
      victim_idx_c   = '0;
      free_idx_c     = '0;
      // scan downward so the lowest matching slot wins
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && keys_ff[i] == key_ff) begin
            hit_c     = 1'b1;
            hit_idx_c = IDX_W'(i);
         end
         if (valid_ff[i] && rank_ff[i] == last_rank) begin
            victim_found_c = 1'b1;
            victim_idx_c   = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_found_c = 1'b1;
            free_idx_c   = IDX_W'(i);
         end
      end
   end

   // Clamp the capacity register to 1..MAX_ENTRIES.
   always_comb begin
      cap_ext   = CMP_W'(cap_ff);
      count_ext = CMP_W'(count_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      full_c = (count_ext >= eff_cap);
   end

   always_comb begin
      tgt       = '0;
      limit     = '0;
      use_limit = 1'b0;
      case (cmd.op)
         OP_HIT: begin
            tgt       = hit_idx_ff;
            limit     = hit_rank_ff;
            use_limit = 1'b1;
         end
         OP_EVICT:  tgt = victim_idx_ff;
         OP_INSERT: tgt = free_idx_ff;
         default:   tgt = '0;
      endcase

      valid_in = valid_ff;
      keys_in  = keys_ff;
      rank_in  = rank_ff;
      count_in = count_ff;

      if (cmd.op != OP_NONE) begin
         // age everything newer than the touched slot
         for (int j = 0; j < MAX_ENTRIES; j++) begin
            if (valid_ff[j] && IDX_W'(j) != tgt && (!use_limit || rank_ff[j] < limit)) begin
               rank_in[j] = rank_ff[j] + RANK_W'(1);
            end
         end
         rank_in[tgt] = '0;
      end
      if (cmd.op == OP_EVICT || cmd.op == OP_INSERT) begin
         keys_in[tgt] = key_ff;
      end
      if (cmd.op == OP_INSERT) begin
         valid_in[tgt] = 1'b1;
         count_in      = count_ff + CNT_W'(1);
      end

      rsp_hit_in      = (cmd.op == OP_HIT);
      rsp_ev_valid_in = (cmd.op == OP_EVICT);
      rsp_ev_key_in   = (cmd.op == OP_EVICT) ? keys_ff[victim_idx_ff] : '0;
      occ_ext         = CMP_W'(count_in);
      rsp_occ_in      = occ_ext[OCC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         count_ff <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_valid) begin
            cap_ff <= csr_wdata;
         end
         if (cmd.finish) begin
            count_ff <= count_in;
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff <= req_key;
      end
      if (cmd.lookup) begin
         hit_ff          <= hit_c;
         full_ff         <= full_c;
         victim_found_ff <= victim_found_c;
         free_found_ff   <= free_found_c;
         hit_idx_ff      <= hit_idx_c;
         victim_idx_ff   <= victim_idx_c;
         free_idx_ff     <= free_idx_c;
         hit_rank_ff     <= rank_ff[hit_idx_c];
      end
      if (cmd.finish) begin
         keys_ff         <= keys_in;
         rank_ff         <= rank_in;
         rsp_hit_ff      <= rsp_hit_in;
         rsp_ev_valid_ff <= rsp_ev_valid_in;
         rsp_ev_key_ff   <= rsp_ev_key_in;
         rsp_occ_ff      <= rsp_occ_in;
      end
   end

   assign sts = '{hit: hit_ff, full: full_ff, victim_found: victim_found_ff,
                  free_found: free_found_ff};

   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_key   = rsp_ev_key_ff;
   assign rsp_occupancy     = rsp_occ_ff;

endmodule

// ----- src/lru_key_tracker.sv -----
// The result strobe rsp_valid is registered after the lookup and update states.
// Each key passes capture, parallel match and rank/key update before the next.
// busy is high in the lookup and update states; results cannot be stalled.
// Reset (synchronous, active high) clears all entries, occupancy and the
// sequencer, and sets the capacity to 16.
// ---------------------------------------------------------------------------
// lru_key_tracker
// Fully associative least-recently-used key store with eviction reporting.
// ---------------------------------------------------------------------------
module lru_key_tracker import lru_kt_pkg::*; #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [KEY_W-1:0] req_key,
   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic             rsp_evicted_valid,
   output logic [KEY_W-1:0] rsp_evicted_key,
   output logic [OCC_W-1:0] rsp_occupancy,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_wdata
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   assign csr_ready = 1'b1;

   lru_kt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .sts       (sts),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   lru_kt_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_key           (req_key),
      .csr_valid         (csr_valid),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_key   (rsp_evicted_key),
      .rsp_occupancy     (rsp_occupancy)
   );

endmodule

// ----- src/lru_kt_checker.sv -----
// ---------------------------------------------------------------------------
// lru_kt_checker
// Port-level checks on the LRU key tracker, bound to the top level.
// ---------------------------------------------------------------------------
module lru_kt_checker import lru_kt_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic             rsp_hit,
   input logic             rsp_evicted_valid,
   input logic [KEY_W-1:0] rsp_evicted_key
);

   a_rsp_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("result strobe missing three cycles after start transfer");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after start transfer");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_evicted_valid)
      else $error("eviction reported on a hit");

   a_evict_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted_valid) |-> (rsp_evicted_key == '0))
      else $error("evicted key nonzero without eviction");

endmodule

bind lru_key_tracker lru_kt_checker u_lru_kt_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_hit           (rsp_hit),
   .rsp_evicted_valid (rsp_evicted_valid),
   .rsp_evicted_key   (rsp_evicted_key)
);

// ----- sim/lru_key_tracker_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lru_key_tracker_tb
// Drives key references through the start/busy port and predicts every
// lookup result (hit, eviction, evicted key, occupancy) with an in-bench LRU
// store. Covers directed hit/insert/evict cases, capacity saturation and
// capacity below occupancy, then random traffic over several capacities
// with random gaps on the request side.
// ---------------------------------------------------------------------------
module lru_key_tracker_tb;
   import lru_kt_pkg::*;

   localparam int ENTRIES     = 16;
   localparam int KEY_POOL    = 24;
   localparam int PHASE_KEYS  = 180;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct {
      logic             hit;
      logic             evicted_valid;
      logic [KEY_W-1:0] evicted_key;
      logic [OCC_W-1:0] occupancy;
   } lookup_result_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [KEY_W-1:0] req_key;
   logic             rsp_valid;
   logic             rsp_hit;
   logic             rsp_evicted_valid;
   logic [KEY_W-1:0] rsp_evicted_key;
   logic [OCC_W-1:0] rsp_occupancy;
   logic             csr_valid;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_wdata;

   // predicted store contents
   logic [KEY_W-1:0] slot_key [ENTRIES];
   logic             slot_valid [ENTRIES];
   int unsigned      slot_rank [ENTRIES];
   int               key_count;
   logic [CAP_W-1:0] capacity_reg;

   lookup_result_type pending_lookups [$];
   logic [KEY_W-1:0]  key_pool [KEY_POOL];
   int                error_count;
   int                cycle_count;

   lru_key_tracker #(
      .MAX_ENTRIES(ENTRIES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_key          (req_key),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_key  (rsp_evicted_key),
      .rsp_occupancy    (rsp_occupancy),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Age every valid entry ranked below limit, except slot skip.
   function automatic void age_younger(input int unsigned limit, input int skip);
      for (int j = 0; j < ENTRIES; j++) begin
         if (slot_valid[j] && j != skip && slot_rank[j] < limit) begin
            slot_rank[j] = slot_rank[j] + 1;
         end
      end
   endfunction

   function automatic lookup_result_type predict_lookup(input logic [KEY_W-1:0] key);
      lookup_result_type res;
      int                found;
      int                victim;
      int                slot;
      int                cap;
      int unsigned       oldest;
      res.hit           = 1'b0;
      res.evicted_valid = 1'b0;
      res.evicted_key   = '0;
      found  = -1;
      victim = -1;
      slot   = -1;
      oldest = 0;
      cap    = (capacity_reg == 0) ? 1 : ((capacity_reg > ENTRIES) ? ENTRIES : capacity_reg);
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
      end
      if (found >= 0) begin
         res.hit = 1'b1;
         age_younger(slot_rank[found], found);
         slot_rank[found] = 0;
      end else if (key_count >= cap) begin
         // oldest entry goes; first slot wins on equal rank
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && (victim < 0 || slot_rank[i] > oldest)) begin
               victim = i;
               oldest = slot_rank[i];
            end
         end
         if (victim >= 0) begin
            res.evicted_valid = 1'b1;
            res.evicted_key   = slot_key[victim];
            age_younger(32'hFFFF_FFFF, victim);
            slot_key[victim]  = key;
            slot_rank[victim] = 0;
         end
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !slot_valid[i]) slot = i;
         end
         if (slot >= 0) begin
            age_younger(32'hFFFF_FFFF, slot);
            slot_valid[slot] = 1'b1;
            slot_key[slot]   = key;
            slot_rank[slot]  = 0;
            key_count++;
         end
      end
      res.occupancy = key_count[OCC_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_lookups.size() == 0) begin
            $error("result with none pending: hit=%0d evicted_key=%h occupancy=%0d",
                   rsp_hit, rsp_evicted_key, rsp_occupancy);
            error_count++;
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
               error_count++;
            end
            if (rsp_evicted_valid !== want.evicted_valid) begin
               $error("evicted_valid: expected %0d, got %0d",
                      want.evicted_valid, rsp_evicted_valid);
               error_count++;
            end
            if (rsp_evicted_key !== want.evicted_key) begin
               $error("evicted_key: expected %h, got %h", want.evicted_key, rsp_evicted_key);
               error_count++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_occupancy);
               error_count++;
            end
         end
      end
   end

   task automatic issue_key(input logic [KEY_W-1:0] key);
      @(negedge clock);
      start   <= 1'b1;
      req_key <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_lookups.push_back(predict_lookup(key));
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drop start, hold until every lookup has returned, then let the pipe drain.
   task automatic settle_lookups();
      @(negedge clock);
      start <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      capacity_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_hit_and_insert();
      issue_key(32'h0000_0000);
      issue_key(32'hFFFF_FFFF);
      issue_key(32'h0000_0000);
      issue_key(32'hFFFF_FFFF);
      issue_key(32'hA5A5_5A5A);
      issue_key(32'h5A5A_A5A5);
   endtask

   // Zero acts as one, and capacity now sits below occupancy.
   task automatic test_capacity_zero();
      settle_lookups();
      write_capacity(5'd0);
      issue_key(32'h0000_0001);
      issue_key(32'h8000_0000);
      issue_key(32'h0000_0001);
   endtask

   // Values above the store size saturate.
   task automatic test_capacity_saturation();
      settle_lookups();
      write_capacity(5'd31);
      issue_key(32'h1234_5678);
      issue_key(32'hFEDC_BA98);
      settle_lookups();
      write_capacity(5'd17);
      issue_key(32'h0F0F_F0F0);
   endtask

   task automatic test_random_traffic();
      logic [CAP_W-1:0] caps [11];
      logic [KEY_W-1:0] key;
      int               r;
      bit               gaps_on;
      caps = '{5'd2, 5'd3, 5'd5, 5'd8, 5'd12, 5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd0};
      caps[10] = CAP_W'($urandom_range(0, 31));
      foreach (caps[p]) begin
         settle_lookups();
         write_capacity(caps[p]);
         foreach (key_pool[i]) key_pool[i] = $urandom();
         gaps_on = (p != 0) && ($urandom_range(0, 2) != 0);
         repeat (PHASE_KEYS) begin
            r = $urandom_range(0, 99);
            if (r < 45) key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            else if (r < 70 && key_count != 0) key = slot_key[$urandom_range(0, key_count - 1)];
            else key = $urandom();
            issue_key(key);
            if (gaps_on) idle_cycles(random_gap());
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_key     = '0;
      csr_valid   = 1'b0;
      csr_wdata   = '0;
      error_count = 0;
      cycle_count = 0;
      key_count   = 0;
      capacity_reg = CAP_RESET;
      foreach (slot_valid[i]) begin
         slot_valid[i] = 1'b0;
         slot_key[i]   = '0;
         slot_rank[i]  = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_hit_and_insert();
      test_capacity_zero();
      test_capacity_saturation();
      test_random_traffic();
      settle_lookups();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
